[rtl/i64d_pkg.sv]
// Package with the shared types and constants of the 64-bit integer divider.
package i64d_pkg;

    localparam int DATA_W = 64;
    localparam int STAGES = DATA_W;

    localparam logic [1:0] OP_UNSIGNED = 2'd0;
    localparam logic [1:0] OP_SIGNED   = 2'd1;
    localparam logic [1:0] OP_COMBINED = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    typedef struct packed {
        logic [1:0]        operation;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic [DATA_W-1:0] quotient;
        logic [DATA_W-1:0] remainder;
        logic              divide_by_zero;
    } div_resp_t;

    // Work carried down the pipeline. The dividend bits shift out of the top of
    // nq while quotient bits shift in at the bottom.
    typedef struct packed {
        logic              q_neg;
        logic              r_neg;
        logic              zero;
        logic              combined;
        logic [DATA_W-1:0] den;
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] nq;
    } work_t;

endpackage

[rtl/i64d_stage.sv]
// One registered restoring-division stage that produces one quotient bit.
module i64d_stage
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            valid_in,
    input  i64d_pkg::work_t work_in,
    output logic            valid_out,
    output i64d_pkg::work_t work_out
);

    logic                        valid_reg;
    i64d_pkg::work_t             work_reg;
    i64d_pkg::work_t             work_next;
    logic [i64d_pkg::DATA_W:0]   shifted;
    logic [i64d_pkg::DATA_W+1:0] diff;
    logic                        take;

    always_comb
    begin
        shifted = {work_in.rem, work_in.nq[i64d_pkg::DATA_W-1]};
        diff    = {1'b0, shifted} - {2'b00, work_in.den};
        take    = ~diff[i64d_pkg::DATA_W+1];
        work_next     = work_in;
        work_next.rem = take ? diff[i64d_pkg::DATA_W-1:0] : shifted[i64d_pkg::DATA_W-1:0];
        work_next.nq  = {work_in.nq[i64d_pkg::DATA_W-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            work_reg <= work_next;
        end
    end

    assign valid_out = valid_reg;
    assign work_out  = work_reg;

endmodule

[rtl/int64_divider_top.sv]
// Top level of the pipelined 64-bit signed and unsigned integer divider.
// The divider takes one request per cycle while nothing stalls. One stage
// forms the operand magnitudes, 64 stages each settle one quotient bit with
// a 65-bit subtract, and one stage applies the signs and drives the result
// register. Each stage advances on its own when the next one has room, so
// empty slots are squeezed out while the result side stalls, and requests
// are refused only once every stage holds work. Division by zero gives a
// zero quotient and raises divide_by_zero; the remainder is then zero, or
// the dividend for the combined operation.
module int64_divider_top
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  i64d_pkg::div_req_t    req_data,
    output logic                  resp_valid,
    input  logic                  resp_stall,
    output i64d_pkg::div_resp_t   resp_data
);

    localparam int LAST = i64d_pkg::STAGES;

    logic                       v   [0:LAST];
    i64d_pkg::work_t            w   [0:LAST];
    logic                       adv [0:LAST+1];

    logic                       v0_reg;
    i64d_pkg::work_t            w0_reg;
    i64d_pkg::work_t            w0_next;
    logic                       out_valid_reg;
    i64d_pkg::div_resp_t        resp_reg;
    i64d_pkg::div_resp_t        resp_next;

    logic                       is_signed;
    logic                       zero;
    logic                       a_neg;
    logic                       b_neg;

    // Stage advance chain: a stage loads when it is empty or its successor moves.
    always_comb
    begin
        adv[LAST+1] = ~out_valid_reg | ~resp_stall;
        for (int k = LAST; k >= 0; k--)
        begin
            adv[k] = ~v[k] | adv[k+1];
        end
    end

    assign req_stall = ~adv[0];

    // Operand magnitudes and sign bookkeeping.
    always_comb
    begin
        is_signed = (req_data.operation != i64d_pkg::OP_UNSIGNED);
        zero      = (req_data.divisor == '0);
        a_neg     = is_signed & req_data.dividend[i64d_pkg::DATA_W-1] & ~zero;
        b_neg     = is_signed & req_data.divisor[i64d_pkg::DATA_W-1];
        w0_next.q_neg    = a_neg ^ b_neg;
        w0_next.r_neg    = a_neg;
        w0_next.zero     = zero;
        w0_next.combined = (req_data.operation == i64d_pkg::OP_COMBINED) ||
                           (req_data.operation == i64d_pkg::OP_RESERVED);
        w0_next.den      = b_neg ? (~req_data.divisor + 1'b1) : req_data.divisor;
        w0_next.rem      = '0;
        // With a zero divisor the raw dividend runs through, which leaves it
        // in the remainder for the combined operation.
        w0_next.nq       = a_neg ? (~req_data.dividend + 1'b1) : req_data.dividend;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (adv[0])
        begin
            v0_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            w0_reg <= w0_next;
        end
    end

    assign v[0] = v0_reg;
    assign w[0] = w0_reg;

    for (genvar s = 1; s <= LAST; s++)
    begin : g_stage
        i64d_stage u_stage
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv[s]),
            .valid_in  (v[s-1]),
            .work_in   (w[s-1]),
            .valid_out (v[s]),
            .work_out  (w[s])
        );
    end

    // Sign correction and zero-divisor handling.
    always_comb
    begin
        resp_next.divide_by_zero = w[LAST].zero;
        if (w[LAST].zero)
        begin
            resp_next.quotient  = '0;
            resp_next.remainder = w[LAST].combined ? w[LAST].rem : '0;
        end
        else
        begin
            resp_next.quotient  = w[LAST].q_neg ? (~w[LAST].nq + 1'b1) : w[LAST].nq;
            resp_next.remainder = w[LAST].r_neg ? (~w[LAST].rem + 1'b1) : w[LAST].rem;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv[LAST+1])
        begin
            out_valid_reg <= v[LAST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[LAST+1])
        begin
            resp_reg <= resp_next;
        end
    end

    assign resp_valid = out_valid_reg;
    assign resp_data  = resp_reg;

    // A zero divisor never produces a non-zero quotient.
    a_zero_quotient: assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid && resp_data.divide_by_zero |-> resp_data.quotient == '0)
        else $error("divide by zero returned a non-zero quotient");

    // Requests are refused only when every stage is full and the result is held.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> resp_valid && resp_stall && v[0] && v[LAST])
        else $error("request refused while the pipeline had room");

    // An accepted request occupies the first stage on the next cycle.
    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> v[0])
        else $error("accepted request did not enter the pipeline");

endmodule
